// ===== hw/rtl/lzvd_pkg.sv =====
`timescale 1ns / 1ps

package lzvd_pkg;

    // decode phase, one-hot
    typedef enum logic [7:0] {
        PH_LEN_LO   = 8'b0000_0001,
        PH_LEN_HI   = 8'b0000_0010,
        PH_OFF_LO   = 8'b0000_0100,
        PH_OFF_HI   = 8'b0000_1000,
        PH_SYMBOL   = 8'b0001_0000,
        PH_COPY     = 8'b0010_0000,
        PH_LITERALS = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } phase_t;

    // item kinds and the expect_next codes
    localparam logic [1:0] FUNC_CTRL = 2'd0;
    localparam logic [1:0] FUNC_SYM  = 2'd1;
    localparam logic [1:0] FUNC_ADV  = 2'd2;
    localparam logic [1:0] EXP_DONE  = 2'd3;

    // section numbers
    localparam logic [1:0] SEC_TILE    = 2'd0;
    localparam logic [1:0] SEC_FLIP    = 2'd1;
    localparam logic [1:0] SEC_PALETTE = 2'd2;
    localparam logic [1:0] SEC_DONE    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TILE    = 2'd0;
    localparam logic [1:0] REG_FLIP    = 2'd1;
    localparam logic [1:0] REG_PALETTE = 2'd2;

    localparam logic [10:0] BYTES_MAX = 11'h7FF;

endpackage

// ===== hw/rtl/lzvd_if.sv =====
`timescale 1ns / 1ps

interface lzvd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] data;

    modport source (output valid, output func, output data, input ready);
    modport sink (input valid, input func, input data, output ready);
endinterface

interface lzvd_out_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [15:0] out_value;
    logic [1:0]  out_section;
    logic        section_last;
    logic [1:0]  expect_next;
    logic        error;

    modport source (output valid, output out_valid, output out_value, output out_section,
                    output section_last, output expect_next, output error, input ready);
    modport sink (input valid, input out_valid, input out_value, input out_section,
                  input section_last, input expect_next, input error, output ready);
endinterface

// ===== hw/rtl/lz_varint_section_decoder.sv =====
`timescale 1ns / 1ps
// A result is registered and presented in the cycle after its input transaction is accepted.
// One transaction per cycle while out_ch.ready is high; copies read the history RAM
//   (one read port, one write port) with forwarding of the value still being written.
// Reset (rst_n, asynchronous, active low): control state and section budgets clear;
//   the history RAM is not cleared, entries are only read after being written.

module lz_varint_section_decoder #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    lzvd_in_if.sink     in_ch,
    lzvd_out_if.source  out_ch
);

    import lzvd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [15:0]   DEPTH16 = 16'(HISTORY_DEPTH);
    localparam logic [AW-1:0] WR_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_DEPTH);

    // state that the section skip touches
    typedef struct packed {
        phase_t        phase;
        logic [1:0]    sec;
        logic [10:0]   bytes;
        logic [FW-1:0] fill;
        logic [AW-1:0] wr;
    } sstate_t;

    // section budgets
    logic [10:0] tile_bytes_reg;
    logic [8:0]  flip_bytes_reg;
    logic [9:0]  pal_bytes_reg;

    // decoder state
    sstate_t     st_reg, st_next;
    logic [14:0] run_reg, run_next;
    logic [14:0] dist_reg, dist_next;
    logic [14:0] left_reg, left_next;

    // result stage
    logic          p_valid_reg;
    logic          p_copy_reg;
    logic          p_wen_reg;
    logic [AW-1:0] p_waddr_reg;
    logic [15:0]   p_sym_reg;
    logic          p_out_valid_reg;
    logic [1:0]    p_sec_reg;
    logic          p_last_reg;
    logic [1:0]    p_exp_reg;
    logic          p_err_reg;
    logic          fwd_hit_reg;
    logic [15:0]   fwd_reg;

    logic          accept;
    logic          leave;
    logic [15:0]   ram_q;
    logic [15:0]   value_cur;

    // step signals
    sstate_t       pre;
    sstate_t       mid;
    logic [1:0]    want;
    logic [7:0]    b;
    logic [14:0]   off;
    logic          err;
    logic          gend;
    logic          valid;
    logic          is_copy;
    logic          wen;
    logic [15:0]   sym;
    logic          last;
    logic [15:0]   idx16;
    logic [AW-1:0] raddr;

    // skip sections whose budget is spent; three sections at most
    function automatic sstate_t settle_f(sstate_t a);
        sstate_t     r;
        logic [10:0] bud;
        r = a;
        for (int i = 0; i < 3; i++)
        begin
            case (r.sec)
                SEC_TILE:    bud = tile_bytes_reg;
                SEC_FLIP:    bud = {2'b00, flip_bytes_reg};
                default:     bud = {1'b0, pal_bytes_reg};
            endcase
            if (r.phase == PH_LEN_LO && r.sec != SEC_DONE && r.bytes >= bud)
            begin
                r.sec   = r.sec + 2'd1;
                r.bytes = '0;
                r.fill  = '0;
                r.wr    = '0;
            end
        end
        if (r.sec == SEC_DONE)
        begin
            r.phase = PH_DONE;
        end
        return r;
    endfunction

    function automatic logic [1:0] want_f(phase_t ph);
        logic [1:0] w;
        case (ph)
            PH_LEN_LO, PH_LEN_HI, PH_OFF_LO, PH_OFF_HI: w = FUNC_CTRL;
            PH_SYMBOL, PH_LITERALS:                     w = FUNC_SYM;
            PH_COPY:                                    w = FUNC_ADV;
            default:                                    w = EXP_DONE;
        endcase
        return w;
    endfunction

    assign leave        = p_valid_reg & out_ch.ready;
    assign in_ch.ready  = ~p_valid_reg | out_ch.ready;
    assign accept       = in_ch.valid & in_ch.ready;

    // budgets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_bytes_reg <= '0;
            flip_bytes_reg <= '0;
            pal_bytes_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TILE:    tile_bytes_reg <= cfg_data;
                REG_FLIP:    flip_bytes_reg <= cfg_data[8:0];
                REG_PALETTE: pal_bytes_reg  <= cfg_data[9:0];
                default:     ;
            endcase
        end
    end

    // one decode step on the accepted transaction
    always_comb
    begin
        pre       = settle_f(st_reg);
        mid       = pre;
        run_next  = run_reg;
        dist_next = dist_reg;
        left_next = left_reg;
        want      = want_f(pre.phase);
        b         = in_ch.data[7:0];
        off       = '0;
        err       = 1'b0;
        gend      = 1'b0;
        valid     = 1'b0;
        is_copy   = 1'b0;
        wen       = 1'b0;
        sym       = '0;

        // copy source in the ring
        if (16'(pre.wr) >= {1'b0, dist_reg})
        begin
            idx16 = 16'(pre.wr) - {1'b0, dist_reg};
        end
        else
        begin
            idx16 = 16'(pre.wr) + DEPTH16 - {1'b0, dist_reg};
        end
        if (idx16 >= DEPTH16)
        begin
            idx16 = '0;
        end
        raddr = idx16[AW-1:0];

        if (pre.phase == PH_DONE || in_ch.func != want)
        begin
            err = 1'b1;
        end
        else
        begin
            case (pre.phase)
                PH_LEN_LO:
                begin
                    if (mid.bytes != BYTES_MAX) mid.bytes = mid.bytes + 11'd1;
                    run_next  = {8'b0, b[6:0]};
                    mid.phase = b[7] ? PH_LEN_HI : PH_OFF_LO;
                end
                PH_LEN_HI:
                begin
                    if (mid.bytes != BYTES_MAX) mid.bytes = mid.bytes + 11'd1;
                    run_next  = {b, run_reg[6:0]};
                    mid.phase = PH_OFF_LO;
                end
                PH_OFF_LO, PH_OFF_HI:
                begin
                    if (pre.phase == PH_OFF_LO && b[7])
                    begin
                        if (mid.bytes != BYTES_MAX) mid.bytes = mid.bytes + 11'd1;
                        dist_next = {8'b0, b[6:0]};
                        mid.phase = PH_OFF_HI;
                    end
                    else
                    begin
                        off = (pre.phase == PH_OFF_LO) ? {7'b0, b} : {b, dist_reg[6:0]};
                        if (run_reg != '0)
                        begin
                            if (off == '0 || {1'b0, off} > DEPTH16
                                || {1'b0, off} > 16'(pre.fill) + 16'd1)
                            begin
                                err = 1'b1;
                            end
                            else
                            begin
                                if (mid.bytes != BYTES_MAX) mid.bytes = mid.bytes + 11'd1;
                                dist_next = off;
                                left_next = run_reg;
                                mid.phase = PH_SYMBOL;
                            end
                        end
                        else
                        begin
                            if (mid.bytes != BYTES_MAX) mid.bytes = mid.bytes + 11'd1;
                            dist_next = off;
                            left_next = off;
                            if (off == '0) gend = 1'b1;
                            else mid.phase = PH_LITERALS;
                        end
                    end
                end
                PH_SYMBOL:
                begin
                    valid     = 1'b1;
                    wen       = 1'b1;
                    sym       = in_ch.data;
                    mid.phase = PH_COPY;
                end
                PH_COPY:
                begin
                    valid   = 1'b1;
                    wen     = 1'b1;
                    is_copy = 1'b1;
                    if (left_reg != '0) left_next = left_reg - 15'd1;
                    if (left_next == '0) gend = 1'b1;
                end
                PH_LITERALS:
                begin
                    valid = 1'b1;
                    wen   = 1'b1;
                    sym   = in_ch.data;
                    if (left_reg != '0) left_next = left_reg - 15'd1;
                    if (left_next == '0) gend = 1'b1;
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end

        // ring push
        if (wen)
        begin
            mid.wr = (pre.wr == WR_LAST) ? '0 : pre.wr + 1'b1;
            if (pre.fill != FILL_MAX) mid.fill = pre.fill + 1'b1;
        end

        if (gend)
        begin
            mid.phase = PH_LEN_LO;
        end
        st_next = settle_f(mid);
        last    = gend && (st_next.sec != pre.sec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase <= PH_LEN_LO;
            st_reg.sec   <= SEC_TILE;
            st_reg.bytes <= '0;
            st_reg.fill  <= '0;
            st_reg.wr    <= '0;
            run_reg      <= '0;
            dist_reg     <= '0;
            left_reg     <= '0;
            p_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg   <= st_next;
                run_reg  <= run_next;
                dist_reg <= dist_next;
                left_reg <= left_next;
            end
            if (accept)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (leave)
            begin
                p_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; forward the value leaving this cycle if the copy hits it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_copy_reg      <= is_copy;
            p_wen_reg       <= wen;
            p_waddr_reg     <= pre.wr;
            p_sym_reg       <= sym;
            p_out_valid_reg <= valid;
            p_sec_reg       <= (pre.sec == SEC_DONE) ? SEC_TILE : pre.sec;
            p_last_reg      <= last;
            p_exp_reg       <= want_f(st_next.phase);
            p_err_reg       <= err;
            fwd_hit_reg     <= p_valid_reg & p_wen_reg & (p_waddr_reg == raddr);
            fwd_reg         <= value_cur;
        end
    end

    assign value_cur = p_copy_reg ? (fwd_hit_reg ? fwd_reg : ram_q) : p_sym_reg;

    lzvd_hist_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .we    (leave & p_wen_reg),
        .waddr (p_waddr_reg),
        .wdata (value_cur),
        .re    (accept & is_copy),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign out_ch.valid        = p_valid_reg;
    assign out_ch.out_valid    = p_out_valid_reg;
    assign out_ch.out_value    = value_cur;
    assign out_ch.out_section  = p_sec_reg;
    assign out_ch.section_last = p_last_reg;
    assign out_ch.expect_next  = p_exp_reg;
    assign out_ch.error        = p_err_reg;

endmodule

// ===== hw/rtl/lzvd_hist_ram.sv =====
`timescale 1ns / 1ps

module lzvd_hist_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-first: a same-cycle write is not seen, the caller forwards
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
